[rtl/core/numeric_literal_scanner_unit_assert.svh]
`ifndef NUMERIC_LITERAL_SCANNER_UNIT_ASSERT_SVH
`define NUMERIC_LITERAL_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define NLS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define NLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/nls_pkg.sv]
package nls_pkg;

    localparam int unsigned COUNT_W = 8;
    localparam logic [COUNT_W-1:0] MAX_LEN = 8'd255;

    localparam int unsigned CHAR_W = 21;

    // classification of one input character; all flags but eot are gated off at end of text
    typedef struct packed {
        logic eot;
        logic dig;
        logic bin;
        logic zero;
        logic xdig;
        logic word;
        logic us;
        logic point;
        logic sign;
        logic exp_e;
        logic exp_p;
        logic radix_b;
        logic radix_x;
        logic d89;
        logic int_sfx;
        logic flt_sfx;
    } nls_class_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        r = v;
        if (v < MAX_LEN)
        begin
            r = v + 8'd1;
        end
        return r;
    endfunction

endpackage

[rtl/core/numeric_literal_scanner_unit.sv]
// numeric literal scanner: takes one character per beat on the input channel
// (char_code, end_of_text) and gives one beat (token_length, malformed) on the
// output channel when a literal ends. A literal starts at a digit or a point;
// characters outside a literal give no output. end_of_text closes any open
// literal. The strict_fraction register is written through cfg_write_en and
// cfg_write_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. The beat ending a literal passes through
// the input register, then into the scan state and the result register.
// throughput: one character per cycle unless a stalled result holds the input
// register; the scan state update is one pass of combinational logic from it.
// when out_stall holds a result, the input register keeps its character and
// in_stall rises only once both the input and result registers are full.
// reset clears the scan state, empties both registers and sets strict_fraction.
module numeric_literal_scanner_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic                        cfg_write_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [nls_pkg::CHAR_W-1:0]  char_code,
    input  logic                        end_of_text,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [nls_pkg::COUNT_W-1:0] token_length,
    output logic                        malformed
);
    import nls_pkg::*;

    `include "numeric_literal_scanner_unit_assert.svh"

    logic              strict_reg;
    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              eot_reg;
    logic              advance;
    logic              accept;
    nls_class_t        cls;

    // the held character moves on unless a stalled result blocks the way
    assign advance  = in_valid_reg && !(out_valid && out_stall);
    assign in_stall = in_valid_reg && out_valid && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg   <= 1'b1;
            in_valid_reg <= 1'b0;
            char_reg     <= '0;
            eot_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                strict_reg <= cfg_write_data;
            in_valid_reg <= in_valid_next;
            if (accept)
            begin
                char_reg <= char_code;
                eot_reg  <= end_of_text;
            end
        end
    end

    nls_char_class u_class (
        .char_code   (char_reg),
        .end_of_text (eot_reg),
        .cls         (cls)
    );

    nls_scan_fsm u_fsm (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .cls             (cls),
        .strict_fraction (strict_reg),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .token_length    (token_length),
        .malformed       (malformed)
    );

    `NLS_ASSERT_SAME(a_no_stall_when_empty, !out_valid, !in_stall, "stall with no result held")
    `NLS_ASSERT_NEXT(a_accept_fills_reg, accept, in_valid_reg, "accepted beat not held")
    `NLS_ASSERT_SAME(a_result_from_char, $rose(out_valid), $past(in_valid_reg), "no held char")

endmodule

[rtl/core/nls_char_class.sv]
module nls_char_class (
    input  logic [nls_pkg::CHAR_W-1:0] char_code,
    input  logic                       end_of_text,
    output nls_pkg::nls_class_t        cls
);
    import nls_pkg::*;

    logic       live;
    logic [6:0] ch;
    logic       is_dig;
    logic       is_lower;
    logic       is_upper;

    // only ascii code points can match anything
    assign live     = !end_of_text && (char_code[CHAR_W-1:7] == '0);
    assign ch       = char_code[6:0];
    assign is_dig   = live && (ch >= 7'h30) && (ch <= 7'h39);
    assign is_lower = live && (ch >= 7'h61) && (ch <= 7'h7a);
    assign is_upper = live && (ch >= 7'h41) && (ch <= 7'h5a);

    always_comb
    begin
        cls.eot     = end_of_text;
        cls.dig     = is_dig;
        cls.bin     = live && ((ch == 7'h30) || (ch == 7'h31));
        cls.zero    = live && (ch == 7'h30);
        cls.xdig    = is_dig
                      || (live && (ch >= 7'h61) && (ch <= 7'h66))
                      || (live && (ch >= 7'h41) && (ch <= 7'h46));
        cls.us      = live && (ch == 7'h5f);
        cls.word    = is_dig || is_lower || is_upper || (live && (ch == 7'h5f));
        cls.point   = live && (ch == 7'h2e);
        cls.sign    = live && ((ch == 7'h2b) || (ch == 7'h2d));
        cls.exp_e   = live && ((ch == 7'h65) || (ch == 7'h45));
        cls.exp_p   = live && ((ch == 7'h70) || (ch == 7'h50));
        cls.radix_b = live && ((ch == 7'h62) || (ch == 7'h42));
        cls.radix_x = live && ((ch == 7'h78) || (ch == 7'h58));
        cls.d89     = live && ((ch == 7'h38) || (ch == 7'h39));
        cls.int_sfx = live && ((ch == 7'h67) || (ch == 7'h6c) || (ch == 7'h69)
                               || (ch == 7'h47) || (ch == 7'h4c) || (ch == 7'h49));
        cls.flt_sfx = live && ((ch == 7'h64) || (ch == 7'h66)
                               || (ch == 7'h44) || (ch == 7'h46));
    end

endmodule

[rtl/core/nls_scan_fsm.sv]
module nls_scan_fsm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  nls_pkg::nls_class_t         cls,
    input  logic                        strict_fraction,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic [nls_pkg::COUNT_W-1:0] token_length,
    output logic                        malformed
);
    import nls_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ZERO,
        PH_BIN_START,
        PH_BIN_DIGITS,
        PH_HEX_START,
        PH_HEX_DIGITS,
        PH_HEX_LEAD_POINT,
        PH_HEX_POINT,
        PH_HEX_FRAC,
        PH_HEX_EXP_SIGN,
        PH_HEX_EXP_START,
        PH_HEX_EXP_DIGITS,
        PH_DEC_INT,
        PH_DEC_POINT,
        PH_DEC_FRAC,
        PH_DEC_EXP_SIGN,
        PH_DEC_EXP_START,
        PH_DEC_EXP_DIGITS,
        PH_DONE_CHECK,
        PH_ERR
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               octal_reg, octal_next;
    logic               nonoct_reg, nonoct_next;
    logic               float_reg, float_next;
    logic               under_reg, under_next;
    logic               point_reg, point_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] len_reg, len_next;
    logic               bad_reg, bad_next;

    logic run_int, run_tail, run_hfrac;
    logic stop_req, stop_bad, fin_req, fin_bad;
    logic emit;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        octal_next  = octal_reg;
        nonoct_next = nonoct_reg;
        float_next  = float_reg;
        under_next  = under_reg;
        point_next  = point_reg;
        run_int     = 1'b0;
        run_tail    = 1'b0;
        run_hfrac   = 1'b0;
        stop_req    = 1'b0;
        stop_bad    = 1'b0;
        fin_req     = 1'b0;
        fin_bad     = 1'b0;
        emit        = 1'b0;

        unique case (phase_reg) inside
            PH_IDLE:
            begin
                if (cls.zero)
                begin
                    count_next = 8'd1;
                    phase_next = PH_ZERO;
                end
                else if (cls.dig)
                begin
                    count_next = 8'd1;
                    under_next = 1'b0;
                    phase_next = PH_DEC_INT;
                end
                else if (cls.point)
                begin
                    count_next = '0;
                    point_next = 1'b1;
                    phase_next = PH_DEC_POINT;
                end
            end
            PH_ZERO:
            begin
                if (cls.radix_b)
                begin
                    count_next = sat_inc(count_next);
                    phase_next = PH_BIN_START;
                end
                else if (cls.radix_x)
                begin
                    count_next = sat_inc(count_next);
                    phase_next = PH_HEX_START;
                end
                else
                begin
                    octal_next = 1'b1;
                    under_next = 1'b0;
                    run_int    = 1'b1;
                end
            end
            PH_BIN_START:
            begin
                if (cls.eot)
                    fin_req = 1'b1;
                else if (!cls.bin)
                begin
                    stop_req = 1'b1;
                    stop_bad = 1'b1;
                end
                else
                begin
                    count_next = sat_inc(count_next);
                    under_next = 1'b0;
                    phase_next = PH_BIN_DIGITS;
                end
            end
            PH_BIN_DIGITS:
            begin
                if (cls.bin || cls.us)
                begin
                    count_next = sat_inc(count_next);
                    under_next = cls.us;
                end
                else if (cls.eot)
                    fin_req = 1'b1;
                else if (under_reg)
                begin
                    stop_req = 1'b1;
                    stop_bad = 1'b1;
                end
                else if (cls.int_sfx)
                begin
                    count_next = sat_inc(count_next);
                    phase_next = PH_DONE_CHECK;
                end
                else
                    stop_req = 1'b1;
            end
            PH_HEX_START:
            begin
                if (cls.eot)
                    fin_req = 1'b1;
                else if (cls.point)
                begin
                    point_next = 1'b1;
                    phase_next = PH_HEX_LEAD_POINT;
                end
                else if (!cls.xdig)
                begin
                    stop_req = 1'b1;
                    stop_bad = 1'b1;
                end
                else
                begin
                    count_next = sat_inc(count_next);
                    under_next = 1'b0;
                    phase_next = PH_HEX_DIGITS;
                end
            end
            PH_HEX_DIGITS:
            begin
                if (cls.xdig || cls.us)
                begin
                    count_next = sat_inc(count_next);
                    under_next = cls.us;
                end
                else if (cls.eot)
                    fin_req = 1'b1;
                else if (under_reg)
                begin
                    stop_req = 1'b1;
                    stop_bad = 1'b1;
                end
                else if (cls.int_sfx)
                begin
                    count_next = sat_inc(count_next);
                    phase_next = PH_DONE_CHECK;
                end
                else if (cls.point)
                begin
                    float_next = 1'b1;
                    point_next = 1'b1;
                    phase_next = PH_HEX_POINT;
                end
                else if (cls.exp_p)
                begin
                    count_next = sat_inc(count_next);
                    float_next = 1'b1;
                    phase_next = PH_HEX_EXP_SIGN;
                end
                else
                    stop_req = 1'b1;
            end
            PH_HEX_LEAD_POINT:
            begin
                point_next = 1'b0;
                if (!cls.xdig)
                begin
                    fin_req = 1'b1;
                    fin_bad = 1'b1;
                end
                else
                begin
                    count_next = sat_inc(count_next);
                    float_next = 1'b1;
                    run_hfrac  = 1'b1;
                end
            end
            PH_HEX_POINT:
            begin
                point_next = 1'b0;
                if (!cls.xdig && strict_fraction)
                    fin_req = 1'b1;
                else
                begin
                    count_next = sat_inc(count_next);
                    run_hfrac  = 1'b1;
                end
            end
            PH_HEX_FRAC:
                run_hfrac = 1'b1;
            PH_HEX_EXP_SIGN, PH_HEX_EXP_START:
            begin
                if ((phase_reg == PH_HEX_EXP_SIGN) && cls.sign)
                begin
                    count_next = sat_inc(count_next);
                    phase_next = PH_HEX_EXP_START;
                end
                else if (cls.eot)
                    fin_req = 1'b1;
                else if (!cls.dig)
                begin
                    stop_req = 1'b1;
                    stop_bad = 1'b1;
                end
                else
                begin
                    count_next = sat_inc(count_next);
                    under_next = 1'b0;
                    phase_next = PH_HEX_EXP_DIGITS;
                end
            end
            PH_HEX_EXP_DIGITS:
            begin
                // a trailing separator is bad here even at end of text
                if (cls.dig || cls.us)
                begin
                    count_next = sat_inc(count_next);
                    under_next = cls.us;
                end
                else if (under_reg)
                begin
                    stop_req = 1'b1;
                    stop_bad = 1'b1;
                end
                else if (cls.flt_sfx)
                begin
                    count_next = sat_inc(count_next);
                    phase_next = PH_DONE_CHECK;
                end
                else
                    stop_req = 1'b1;
            end
            PH_DEC_INT:
                run_int = 1'b1;
            PH_DEC_POINT:
            begin
                point_next = 1'b0;
                if (!cls.dig && (strict_fraction || (count_reg == '0)))
                    fin_req = 1'b1;
                else
                begin
                    count_next = sat_inc(count_next);
                    float_next = 1'b1;
                    under_next = 1'b0;
                    if (cls.eot)
                        fin_req = 1'b1;
                    else if (cls.dig)
                    begin
                        count_next = sat_inc(count_next);
                        phase_next = PH_DEC_FRAC;
                    end
                    else
                        run_tail = 1'b1;
                end
            end
            PH_DEC_FRAC:
            begin
                if (cls.dig || cls.us)
                begin
                    count_next = sat_inc(count_next);
                    under_next = cls.us;
                end
                else if (cls.eot)
                    fin_req = 1'b1;
                else if (under_reg)
                begin
                    stop_req = 1'b1;
                    stop_bad = 1'b1;
                end
                else
                    run_tail = 1'b1;
            end
            PH_DEC_EXP_SIGN, PH_DEC_EXP_START:
            begin
                if ((phase_reg == PH_DEC_EXP_SIGN) && cls.sign)
                begin
                    count_next = sat_inc(count_next);
                    phase_next = PH_DEC_EXP_START;
                end
                else if (cls.eot)
                    fin_req = 1'b1;
                else if (!cls.dig)
                begin
                    stop_req = 1'b1;
                    stop_bad = 1'b1;
                end
                else
                begin
                    count_next = sat_inc(count_next);
                    under_next = 1'b0;
                    phase_next = PH_DEC_EXP_DIGITS;
                end
            end
            PH_DEC_EXP_DIGITS:
            begin
                if (cls.dig || cls.us)
                begin
                    count_next = sat_inc(count_next);
                    under_next = cls.us;
                end
                else if (cls.eot)
                    fin_req = 1'b1;
                else if (under_reg)
                begin
                    stop_req = 1'b1;
                    stop_bad = 1'b1;
                end
                else if (cls.flt_sfx)
                begin
                    count_next = sat_inc(count_next);
                    phase_next = PH_DONE_CHECK;
                end
                else
                    stop_req = 1'b1;
            end
            PH_DONE_CHECK:
                stop_req = 1'b1;
            PH_ERR:
            begin
                if (cls.word)
                    count_next = sat_inc(count_next);
                else
                begin
                    fin_req = 1'b1;
                    fin_bad = 1'b1;
                end
            end
            default:
            begin
                phase_next  = PH_IDLE;
                count_next  = '0;
                octal_next  = 1'b0;
                nonoct_next = 1'b0;
                float_next  = 1'b0;
                under_next  = 1'b0;
                point_next  = 1'b0;
            end
        endcase

        // decimal integer digits, shared by the leading-zero and decimal phases
        if (run_int)
        begin
            if (cls.dig || cls.us)
            begin
                count_next = sat_inc(count_next);
                if (cls.d89)
                    nonoct_next = 1'b1;
                under_next = cls.us;
                phase_next = PH_DEC_INT;
            end
            else if (cls.eot)
                fin_req = 1'b1;
            else if (under_next)
            begin
                stop_req = 1'b1;
                stop_bad = 1'b1;
            end
            else if (cls.point)
            begin
                point_next = 1'b1;
                phase_next = PH_DEC_POINT;
            end
            else
                run_tail = 1'b1;
        end

        // exponent, suffix or end after a decimal mantissa
        if (run_tail)
        begin
            if (cls.exp_e)
            begin
                count_next = sat_inc(count_next);
                float_next = 1'b1;
                phase_next = PH_DEC_EXP_SIGN;
            end
            else if (cls.flt_sfx)
            begin
                count_next = sat_inc(count_next);
                float_next = 1'b1;
                phase_next = PH_DONE_CHECK;
            end
            else if (cls.eot)
                fin_req = 1'b1;
            else if (!float_next && octal_next && nonoct_next)
            begin
                stop_req = 1'b1;
                stop_bad = 1'b1;
            end
            else if (!float_next && cls.int_sfx)
            begin
                count_next = sat_inc(count_next);
                phase_next = PH_DONE_CHECK;
            end
            else
                stop_req = 1'b1;
        end

        if (run_hfrac)
        begin
            phase_next = PH_HEX_FRAC;
            if (cls.xdig || cls.us)
                count_next = sat_inc(count_next);
            else if (cls.eot)
                fin_req = 1'b1;
            else if (cls.exp_p)
            begin
                count_next = sat_inc(count_next);
                phase_next = PH_HEX_EXP_SIGN;
            end
            else
            begin
                stop_req = 1'b1;
                stop_bad = 1'b1;
            end
        end

        // a word character right after the literal opens a bad run
        if (stop_req)
        begin
            if (cls.word)
            begin
                count_next = sat_inc(count_next);
                phase_next = PH_ERR;
            end
            else
            begin
                fin_req = 1'b1;
                fin_bad = stop_bad;
            end
        end

        len_next = count_next;
        if (fin_req)
        begin
            emit        = 1'b1;
            phase_next  = PH_IDLE;
            count_next  = '0;
            octal_next  = 1'b0;
            nonoct_next = 1'b0;
            float_next  = 1'b0;
            under_next  = 1'b0;
            point_next  = 1'b0;
        end
        bad_next = fin_bad;

        if (advance && emit)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            octal_reg     <= 1'b0;
            nonoct_reg    <= 1'b0;
            float_reg     <= 1'b0;
            under_reg     <= 1'b0;
            point_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                octal_reg  <= octal_next;
                nonoct_reg <= nonoct_next;
                float_reg  <= float_next;
                under_reg  <= under_next;
                point_reg  <= point_next;
            end
            if (advance && emit)
            begin
                len_reg <= len_next;
                bad_reg <= bad_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign token_length = len_reg;
    assign malformed    = bad_reg;

endmodule
